// ===== sv/ising_ring_metropolis_update_defines.svh =====
// Assertion macros shared by the ring update RTL.
// Included by files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef ISING_RING_METROPOLIS_UPDATE_DEFINES_SVH
`define ISING_RING_METROPOLIS_UPDATE_DEFINES_SVH
`ifndef SYNTH
// check outside reset
`define IRM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check on every edge, reset included
`define IRM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define IRM_ASSERT(label, prop, msg)
`define IRM_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== sv/irm_pkg.sv =====
// Shared types and constants of the Ising ring Metropolis update block.
// No dependencies; used by irm_cell, irm_tree and the top level.
package irm_pkg;

  localparam int SITE_W = 6;
  localparam int LEN_W  = 7;
  localparam int THR_W  = 16;
  localparam int RAND_W = 16;
  localparam int SUM_W  = 8;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // item function codes
  localparam logic [1:0] FUNC_UPDATE  = 2'd0;
  localparam logic [1:0] FUNC_LOAD    = 2'd1;
  localparam logic [1:0] FUNC_MEASURE = 2'd2;
  localparam logic [1:0] FUNC_RSVD    = 2'd3;

  // register index, taken from paddr[2]
  localparam logic REG_RING_LENGTH = 1'b0;
  localparam logic REG_ACCEPT_THR  = 1'b1;

  localparam logic [LEN_W-1:0] RING_LENGTH_RST = 7'd64;
  localparam logic [THR_W-1:0] ACCEPT_THR_RST  = 16'd1200;

  typedef struct packed {
    logic [1:0]        func;
    logic [SITE_W-1:0] site;
    logic [RAND_W-1:0] rand_fraction;
    logic              spin_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic                    flipped;
    logic                    error;
    logic                    spin_now;
    logic signed [SUM_W-1:0] magnetization;
    logic signed [SUM_W-1:0] energy;
    logic [SITE_W-1:0]       distance;
    logic signed [SUM_W-1:0] correlation;
    logic                    last;
  } out_item_t;

  // what a pipeline slot carries to the output stage
  typedef enum logic [1:0] {
    SLOT_RESULT,
    SLOT_MAG,
    SLOT_ENERGY,
    SLOT_CORR
  } slot_e;

  typedef struct packed {
    logic              valid;
    slot_e             slot;
    logic [1:0]        kind;
    logic              flipped;
    logic              error;
    logic              spin_now;
    logic [SITE_W-1:0] distance;
    logic              last;
  } tag_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic              update;
    logic              load;
    logic              load_val;
    logic              uphill_ok;
    logic [SITE_W-1:0] site;
    logic [LEN_W-1:0]  len;
    logic              shadow_rot;
    logic              shadow_copy;
    logic              shadow_shift;
    logic              count_up;
  } cell_ctl_t;

  // status from one cell
  typedef struct packed {
    logic spin;
    logic shadow;
    logic tap;
    logic tail;
    logic flip;
    logic spin_hit;
  } cell_stat_t;

endpackage

// ===== sv/irm_cell.sv =====
// One ring site: its spin, a shadow copy that rotates for correlations, local Metropolis rule.
// Depends on irm_pkg.
module irm_cell #(
  parameter int IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  irm_pkg::cell_ctl_t ctl_i,
  input  logic             left_spin_i,
  input  logic             right_spin_i,
  input  logic             right_shadow_i,
  input  logic             first_spin_i,
  input  logic             first_shadow_i,
  output irm_pkg::cell_stat_t stat_o
);
  import irm_pkg::*;

  logic spin_q, spin_d;
  logic shadow_q, shadow_d;
  logic is_last, in_use, hit;
  logic right_spin, right_shadow;
  logic uphill, accept, flip;

  // periodic wrap at the active ring length
  assign is_last      = ctl_i.len == LEN_W'(IDX + 1);
  assign in_use       = LEN_W'(IDX) < ctl_i.len;
  assign right_spin   = is_last ? first_spin_i : right_spin_i;
  assign right_shadow = is_last ? first_shadow_i : right_shadow_i;
  assign hit          = ctl_i.site == SITE_W'(IDX);

  // dE = +4 only when both neighbors match this spin
  assign uphill = (spin_q == left_spin_i) && (spin_q == right_spin);
  assign accept = !uphill || ctl_i.uphill_ok;
  assign flip   = ctl_i.update && hit && accept;

  always_comb begin
    spin_d = spin_q;
    if (ctl_i.load && hit) begin
      spin_d = ctl_i.load_val;
    end else if (flip) begin
      spin_d = ~spin_q;
    end
  end

  always_comb begin
    shadow_d = shadow_q;
    if (ctl_i.shadow_rot) begin
      shadow_d = right_spin;
    end else if (ctl_i.shadow_copy) begin
      shadow_d = spin_q;
    end else if (ctl_i.shadow_shift) begin
      shadow_d = right_shadow;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spin_q <= 1'b1;
    end else begin
      spin_q <= spin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shadow_q <= shadow_d;
  end

  // status back to the top
  assign stat_o.spin     = spin_q;
  assign stat_o.shadow   = shadow_q;
  assign stat_o.tap      = in_use && (ctl_i.count_up ? spin_q : (spin_q ~^ shadow_q));
  assign stat_o.tail     = is_last && spin_q;
  assign stat_o.flip     = flip;
  assign stat_o.spin_hit = (ctl_i.update || ctl_i.load) && hit && spin_d;

endmodule

// ===== sv/irm_tree.sv =====
// Two-level registered population count over the cell taps.
// Depends on irm_pkg only for house style; it uses no shared types or widths from it.
module irm_tree #(
  parameter int N_TAPS = 64
) (
  input  logic                        clk_i,
  input  logic                        adv_i,
  input  logic [N_TAPS-1:0]           taps_i,
  output logic [$clog2(N_TAPS+1)-1:0] count_o
);
  import irm_pkg::*;

  localparam int GRP    = 8;
  localparam int NGRP   = (N_TAPS + GRP - 1) / GRP;
  localparam int PAD_W  = NGRP * GRP;
  localparam int GCNT_W = $clog2(GRP + 1);
  localparam int CNT_W  = $clog2(N_TAPS + 1);

  logic [PAD_W-1:0]  taps_pad;
  logic [GCNT_W-1:0] gcnt_d [NGRP];
  logic [GCNT_W-1:0] gcnt_q [NGRP];
  logic [CNT_W-1:0]  total_d, total_q;

  assign taps_pad = PAD_W'(taps_i);

  // group counts, eight taps each
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      gcnt_d[g] = '0;
      for (int b = 0; b < GRP; b++) begin
        gcnt_d[g] = gcnt_d[g] + GCNT_W'(taps_pad[g*GRP+b]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      gcnt_q <= gcnt_d;
    end
  end

  // sum of the group counts
  always_comb begin
    total_d = '0;
    for (int g = 0; g < NGRP; g++) begin
      total_d = total_d + CNT_W'(gcnt_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      total_q <= total_d;
    end
  end

  assign count_o = total_q;

endmodule

// ===== sv/ising_ring_metropolis_update.sv =====
// Update, load and error items: one per cycle unless stalled, each result registered in
// p1, p2 and the output stage. Measure: new requests stall while the sequencer runs its
// energy and correlation states; L results stream one per cycle unless stalled, paced by
// the cell shift chain and the two-stage count tree. An output stall freezes the whole
// pipeline. Reset: every spin up, ring_length 64, accept_threshold 1200, pipeline empty.
module ising_ring_metropolis_update #(
  parameter int MAX_SITES = 64,
  parameter int RAND_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  irm_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output irm_pkg::out_item_t         out_item_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [irm_pkg::APB_AW-1:0] paddr,
  input  logic [irm_pkg::APB_DW-1:0] pwdata,
  output logic [irm_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import irm_pkg::*;

`include "ising_ring_metropolis_update_defines.svh"

  localparam int CNT_W     = $clog2(MAX_SITES + 1);
  localparam int MASK_BITS = (RAND_BITS < RAND_W) ? RAND_BITS : RAND_W;
  localparam int CMP_W     = 2 * RAND_W + RAND_BITS;
  localparam logic [RAND_W:0] RMASK = (RAND_W+1)'((RAND_W+1)'(1) << MASK_BITS) - 1'b1;

  typedef enum logic [2:0] {
    SEQ_IDLE   = 3'b001,
    SEQ_ENERGY = 3'b010,
    SEQ_CORR   = 3'b100
  } seq_e;

  logic [LEN_W-1:0]  ring_length_q;
  logic [THR_W-1:0]  thr_q;
  logic [LEN_W-1:0]  len;
  seq_e              seq_q, seq_d;
  logic [SITE_W-1:0] dist_q, dist_d;
  logic              adv, in_acc, site_ok, corr_last, uphill_ok;
  logic [RAND_W-1:0] rnd_m;
  logic [CMP_W-1:0]  cmp_r, cmp_t;
  cell_ctl_t         ctl;
  cell_stat_t        stat_w [MAX_SITES];
  logic [MAX_SITES-1:0] taps;
  logic              flip_any, spin_now_any, tail_spin;
  logic [CNT_W-1:0]  tree_cnt;
  tag_t              p0, p1_q, p2_q;
  logic [SUM_W:0]    cnt_x, len_x, dev, neg_dev;
  logic signed [SUM_W-1:0] mag_q, en_q;
  logic              out_valid_q;
  out_item_t         out_item_q, out_item_d;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_length_q <= RING_LENGTH_RST;
      thr_q         <= ACCEPT_THR_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_RING_LENGTH) begin
        ring_length_q <= pwdata[LEN_W-1:0];
      end else begin
        thr_q <= pwdata[THR_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_RING_LENGTH) ? APB_DW'(ring_length_q) : APB_DW'(thr_q);

  // active ring length, clamped
  always_comb begin
    if (ring_length_q < LEN_W'(2)) begin
      len = LEN_W'(2);
    end else if (ring_length_q > LEN_W'(MAX_SITES)) begin
      len = LEN_W'(MAX_SITES);
    end else begin
      len = ring_length_q;
    end
  end

  // handshake
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !((seq_q == SEQ_IDLE) && adv);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign site_ok    = LEN_W'(in_item_i.site) < len;
  assign corr_last  = LEN_W'(dist_q) == (len - LEN_W'(1));

  // exact uphill acceptance: r * 2^16 < t * 2^RAND_BITS
  assign rnd_m     = in_item_i.rand_fraction & RMASK[RAND_W-1:0];
  assign cmp_r     = CMP_W'(rnd_m) << RAND_W;
  assign cmp_t     = CMP_W'(thr_q) << RAND_BITS;
  assign uphill_ok = cmp_r < cmp_t;

  // broadcast to the cells
  always_comb begin
    ctl              = '0;
    ctl.update       = in_acc && (in_item_i.func == FUNC_UPDATE) && site_ok;
    ctl.load         = in_acc && (in_item_i.func == FUNC_LOAD) && site_ok;
    ctl.load_val     = in_item_i.spin_value;
    ctl.uphill_ok    = uphill_ok;
    ctl.site         = in_item_i.site;
    ctl.len          = len;
    ctl.shadow_rot   = in_acc && (in_item_i.func == FUNC_MEASURE);
    ctl.shadow_copy  = (seq_q == SEQ_ENERGY) && adv;
    ctl.shadow_shift = (seq_q == SEQ_CORR) && adv;
    ctl.count_up     = seq_q == SEQ_IDLE;
  end

  // the ring of cells
  for (genvar i = 0; i < MAX_SITES; i++) begin : g_cell
    localparam int NXT = (i + 1) % MAX_SITES;
    localparam int PRV = (i + MAX_SITES - 1) % MAX_SITES;
    logic left_spin;

    assign left_spin = (i == 0) ? tail_spin : stat_w[PRV].spin;

    irm_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .left_spin_i   (left_spin),
      .right_spin_i  (stat_w[NXT].spin),
      .right_shadow_i(stat_w[NXT].shadow),
      .first_spin_i  (stat_w[0].spin),
      .first_shadow_i(stat_w[0].shadow),
      .stat_o        (stat_w[i])
    );

    assign taps[i] = stat_w[i].tap;
  end

  // gather cell status
  always_comb begin
    flip_any     = 1'b0;
    spin_now_any = 1'b0;
    tail_spin    = 1'b0;
    for (int i = 0; i < MAX_SITES; i++) begin
      flip_any     = flip_any | stat_w[i].flip;
      spin_now_any = spin_now_any | stat_w[i].spin_hit;
      tail_spin    = tail_spin | stat_w[i].tail;
    end
  end

  irm_tree #(
    .N_TAPS(MAX_SITES)
  ) u_tree (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .taps_i (taps),
    .count_o(tree_cnt)
  );

  // measure sequencer
  always_comb begin
    seq_d  = seq_q;
    dist_d = dist_q;
    case (seq_q)
      SEQ_IDLE: begin
        if (in_acc && (in_item_i.func == FUNC_MEASURE)) begin
          seq_d = SEQ_ENERGY;
        end
      end
      SEQ_ENERGY: begin
        if (adv) begin
          seq_d  = SEQ_CORR;
          dist_d = '0;
        end
      end
      SEQ_CORR: begin
        if (adv) begin
          if (corr_last) begin
            seq_d = SEQ_IDLE;
          end else begin
            dist_d = dist_q + 1'b1;
          end
        end
      end
      default: begin
        seq_d = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= SEQ_IDLE;
      dist_q <= '0;
    end else begin
      seq_q  <= seq_d;
      dist_q <= dist_d;
    end
  end

  // issue slot tag
  always_comb begin
    p0 = '0;
    case (seq_q)
      SEQ_IDLE: begin
        if (in_acc) begin
          p0.valid = 1'b1;
          p0.kind  = in_item_i.func;
          p0.last  = 1'b1;
          if (in_item_i.func == FUNC_MEASURE) begin
            p0.slot = SLOT_MAG;
          end else begin
            p0.slot     = SLOT_RESULT;
            p0.error    = (in_item_i.func == FUNC_RSVD) || !site_ok;
            p0.flipped  = flip_any;
            p0.spin_now = spin_now_any;
          end
        end
      end
      SEQ_ENERGY: begin
        p0.valid = 1'b1;
        p0.slot  = SLOT_ENERGY;
        p0.kind  = FUNC_MEASURE;
      end
      SEQ_CORR: begin
        p0.valid    = 1'b1;
        p0.slot     = SLOT_CORR;
        p0.kind     = FUNC_MEASURE;
        p0.distance = dist_q;
        p0.last     = corr_last;
      end
      default: begin
        p0 = '0;
      end
    endcase
  end

  // tags follow the count tree
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '0;
      p2_q <= '0;
    end else if (adv) begin
      p1_q <= p0;
      p2_q <= p1_q;
    end
  end

  // count to signed sum: 2c - L, and L - 2c for the energy
  assign cnt_x   = (SUM_W+1)'(tree_cnt);
  assign len_x   = (SUM_W+1)'(len);
  assign dev     = (cnt_x << 1) - len_x;
  assign neg_dev = len_x - (cnt_x << 1);

  always_comb begin
    out_item_d          = '0;
    out_item_d.kind     = p2_q.kind;
    out_item_d.flipped  = p2_q.flipped;
    out_item_d.error    = p2_q.error;
    out_item_d.spin_now = p2_q.spin_now;
    out_item_d.distance = p2_q.distance;
    out_item_d.last     = p2_q.last;
    if (p2_q.slot == SLOT_CORR) begin
      out_item_d.magnetization = mag_q;
      out_item_d.energy        = en_q;
      out_item_d.correlation   = signed'(dev[SUM_W-1:0]);
    end
  end

  // output stage and measure sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= p2_q.valid && ((p2_q.slot == SLOT_RESULT) || (p2_q.slot == SLOT_CORR));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_q <= out_item_d;
      if (p2_q.valid && (p2_q.slot == SLOT_MAG)) begin
        mag_q <= signed'(dev[SUM_W-1:0]);
      end
      if (p2_q.valid && (p2_q.slot == SLOT_ENERGY)) begin
        en_q <= signed'(neg_dev[SUM_W-1:0]);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // checks
  `IRM_ASSERT_ALWAYS(a_busy_stalls, (seq_q != SEQ_IDLE) |-> in_stall_o, "request taken during measure")
  `IRM_ASSERT(a_single_last, out_valid_o && (out_item_o.kind != FUNC_MEASURE) |-> out_item_o.last, "non-measure result without last")
  `IRM_ASSERT(a_err_no_effect, out_valid_o && out_item_o.error |-> !out_item_o.flipped && !out_item_o.spin_now, "error result reports a spin")
  `IRM_ASSERT(a_load_no_flip, out_valid_o && (out_item_o.kind == FUNC_LOAD) |-> !out_item_o.flipped, "load result flagged as flip")
  `IRM_ASSERT(a_issue_src, p0.valid |-> in_acc || (seq_q != SEQ_IDLE), "slot issued without request")

endmodule

// ===== dv/tb_ising_ring_metropolis_update.sv =====
// Self-checking testbench for the Ising ring Metropolis update block: a directed table,
// then random request phases across register settings, each result checked in order.
// Depends on irm_pkg and the ising_ring_metropolis_update RTL only.
module tb_ising_ring_metropolis_update;
  timeunit 1ns;
  timeprecision 1ps;

  import irm_pkg::*;

  localparam int RING_MAX      = 64;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 80;
  localparam int PHASE_COUNT   = 8;

  localparam logic [APB_AW-1:0] ADDR_RING_LENGTH = {REG_RING_LENGTH, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_ACCEPT_THR  = {REG_ACCEPT_THR, 2'b00};

  // random phases: ring_length written, threshold written (-1 draws one), request count
  localparam int PHASE_LEN[PHASE_COUNT] = '{64, 2, 5, 12, 0, 100, 37, 20};
  localparam int PHASE_THR[PHASE_COUNT] = '{1200, 0, 65535, 30000, -1, 8000, -1, 40000};
  localparam int PHASE_REQ[PHASE_COUNT] = '{30, 12, 22, 25, 8, 15, 20, 25};

  typedef enum logic {ROW_REQUEST, ROW_REG_WRITE} row_kind_e;

  typedef struct {
    row_kind_e         op;
    in_item_t          req;
    bit                known;
    out_item_t         want;
    logic [APB_AW-1:0] addr;
    logic [APB_DW-1:0] data;
  } stim_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_item_t          in_item_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_item_t         out_item_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // our own copy of the ring and the registers
  logic [RING_MAX-1:0] ring_spins;
  logic [LEN_W-1:0]    ring_len_reg;
  logic [THR_W-1:0]    thr_reg;

  out_item_t ring_results_due[$];
  out_item_t fresh_results[$];
  stim_row_t directed_rows[$];
  int        mismatch_count = 0;
  int        idle_cycles    = 0;
  int        stall_left     = 0;
  bit        calm_tail      = 1'b0;

  ising_ring_metropolis_update uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5ns clk_i = ~clk_i;

  // ring length in use: register clamped to [2, 64]
  function automatic int active_len();
    if (ring_len_reg < 2) return 2;
    if (ring_len_reg > RING_MAX) return RING_MAX;
    return int'(ring_len_reg);
  endfunction

  function automatic int spin_pm(int i);
    return ring_spins[i] ? 1 : -1;
  endfunction

  // Metropolis ring behavior: fills fresh_results with what one request produces
  function automatic void predict_ring_item(input in_item_t req);
    int        len, s, left, right, mag, en, corr, j;
    bit        uphill, accept;
    out_item_t r;
    fresh_results.delete();
    len = active_len();
    s = int'(req.site);
    r = '0;
    r.kind = req.func;
    r.last = 1'b1;
    case (req.func)
      FUNC_UPDATE, FUNC_LOAD: begin
        if (s >= len) begin
          r.error = 1'b1;
        end else if (req.func == FUNC_LOAD) begin
          ring_spins[s] = req.spin_value;
          r.spin_now = req.spin_value;
        end else begin
          right = (s + 1 < len) ? s + 1 : 0;
          left = (s == 0) ? len - 1 : s - 1;
          uphill = (spin_pm(s) * (spin_pm(left) + spin_pm(right))) > 0;
          // RAND_BITS equals the threshold width, so the fractions compare directly
          accept = !uphill || (req.rand_fraction < thr_reg);
          if (accept) ring_spins[s] = ~ring_spins[s];
          r.flipped = accept;
          r.spin_now = ring_spins[s];
        end
        fresh_results.push_back(r);
      end
      FUNC_MEASURE: begin
        mag = 0;
        en = 0;
        for (int i = 0; i < len; i++) begin
          right = (i + 1 < len) ? i + 1 : 0;
          mag += spin_pm(i);
          en -= spin_pm(i) * spin_pm(right);
        end
        for (int d = 0; d < len; d++) begin
          corr = 0;
          for (int i = 0; i < len; i++) begin
            j = i + d;
            if (j >= len) j -= len;
            corr += spin_pm(i) * spin_pm(j);
          end
          r = '0;
          r.kind = FUNC_MEASURE;
          r.magnetization = mag[SUM_W-1:0];
          r.energy = en[SUM_W-1:0];
          r.distance = d[SITE_W-1:0];
          r.correlation = corr[SUM_W-1:0];
          r.last = (d == len - 1);
          fresh_results.push_back(r);
        end
      end
      default: begin
        r.error = 1'b1;
        fresh_results.push_back(r);
      end
    endcase
  endfunction

  function automatic out_item_t known_result(logic [1:0] kind, bit flipped, bit error,
                                             bit spin_now);
    out_item_t r;
    r = '0;
    r.kind = kind;
    r.flipped = flipped;
    r.error = error;
    r.spin_now = spin_now;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t plain_row(logic [1:0] func, int site, int rnd, bit spin);
    stim_row_t row;
    row.op = ROW_REQUEST;
    row.req.func = func;
    row.req.site = site[SITE_W-1:0];
    row.req.rand_fraction = rnd[RAND_W-1:0];
    row.req.spin_value = spin;
    row.known = 1'b0;
    row.want = '0;
    row.addr = '0;
    row.data = '0;
    return row;
  endfunction

  function automatic stim_row_t known_row(logic [1:0] func, int site, int rnd, bit spin,
                                          out_item_t want);
    stim_row_t row;
    row = plain_row(func, site, rnd, spin);
    row.known = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t reg_row(logic [APB_AW-1:0] addr, int data);
    stim_row_t row;
    row = plain_row(FUNC_UPDATE, 0, 0, 1'b0);
    row.op = ROW_REG_WRITE;
    row.addr = addr;
    row.data = data;
    return row;
  endfunction

  // random request, mostly in range, with thresholds probed near their edge
  function automatic in_item_t random_request();
    in_item_t req;
    int       len, pick, t;
    len = active_len();
    pick = $urandom_range(99);
    req.spin_value = 1'($urandom_range(1));
    req.site = SITE_W'($urandom_range(len - 1));
    if (pick < 55) begin
      req.func = FUNC_UPDATE;
    end else if (pick < 80) begin
      req.func = FUNC_LOAD;
    end else if (pick < 88) begin
      req.func = FUNC_MEASURE;
      req.site = SITE_W'($urandom_range(RING_MAX - 1));
    end else if (pick < 92) begin
      req.func = FUNC_RSVD;
      req.site = SITE_W'($urandom_range(RING_MAX - 1));
    end else begin
      // site past the ring end, when the ring is shorter than RING_MAX
      req.func = pick[0] ? FUNC_UPDATE : FUNC_LOAD;
      req.site = (len < RING_MAX) ? SITE_W'($urandom_range(RING_MAX - 1, len))
                                  : SITE_W'($urandom_range(RING_MAX - 1));
    end
    case ($urandom_range(3))
      0, 1: req.rand_fraction = RAND_W'($urandom_range(65535));
      2: begin
        t = int'(thr_reg) + int'($urandom_range(4)) - 2;
        if (t < 0) t = 0;
        if (t > 65535) t = 65535;
        req.rand_fraction = t[RAND_W-1:0];
      end
      default: req.rand_fraction = pick[1] ? '0 : '1;
    endcase
    return req;
  endfunction

  // drive one request until accepted, then queue what it should produce
  task automatic send_request(input in_item_t req, input bit known, input out_item_t want);
    in_valid_i <= 1'b1;
    in_item_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    predict_ring_item(req);
    if (known) begin
      ring_results_due.push_back(want);
    end else begin
      foreach (fresh_results[k]) ring_results_due.push_back(fresh_results[k]);
    end
  endtask

  // hold requests off until every expected result is back
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (ring_results_due.size() != 0);
  endtask

  task automatic write_reg(input logic [APB_AW-1:0] addr, input int data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_RING_LENGTH) ring_len_reg = data[LEN_W-1:0];
    else thr_reg = data[THR_W-1:0];
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (ring_results_due.size() == 0) begin
      $error("result with none expected: kind %0d distance %0d", got.kind, got.distance);
      mismatch_count++;
      return;
    end
    want = ring_results_due.pop_front();
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      mismatch_count++;
    end
    if (got.flipped !== want.flipped) begin
      $error("flipped: expected %0d, got %0d", want.flipped, got.flipped);
      mismatch_count++;
    end
    if (got.error !== want.error) begin
      $error("error: expected %0d, got %0d", want.error, got.error);
      mismatch_count++;
    end
    if (got.spin_now !== want.spin_now) begin
      $error("spin_now: expected %0d, got %0d", want.spin_now, got.spin_now);
      mismatch_count++;
    end
    if (got.magnetization !== want.magnetization) begin
      $error("magnetization: expected %0d, got %0d", want.magnetization, got.magnetization);
      mismatch_count++;
    end
    if (got.energy !== want.energy) begin
      $error("energy: expected %0d, got %0d", want.energy, got.energy);
      mismatch_count++;
    end
    if (got.distance !== want.distance) begin
      $error("distance: expected %0d, got %0d", want.distance, got.distance);
      mismatch_count++;
    end
    if (got.correlation !== want.correlation) begin
      $error("correlation: expected %0d, got %0d", want.correlation, got.correlation);
      mismatch_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      mismatch_count++;
    end
  endtask

  // result side: check accepted results, stall in random bursts
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_item_o);
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (rst_ni && !calm_tail && $urandom_range(9) == 0) begin
      stall_left = $urandom_range(16, 1) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_ising_ring_metropolis_update: FAIL");
      $finish;
    end
  end

  initial begin
    int thr;
    ring_spins = '1;
    ring_len_reg = RING_LENGTH_RST;
    thr_reg = ACCEPT_THR_RST;

    // directed: reset state, threshold boundary, out-of-range sites, clamped lengths
    directed_rows.push_back(plain_row(FUNC_MEASURE, 0, 0, 1'b0));
    directed_rows.push_back(known_row(FUNC_UPDATE, 0, 65535, 1'b0,
                                      known_result(FUNC_UPDATE, 0, 0, 1)));
    directed_rows.push_back(known_row(FUNC_UPDATE, 0, 0, 1'b0,
                                      known_result(FUNC_UPDATE, 1, 0, 0)));
    directed_rows.push_back(known_row(FUNC_UPDATE, 0, 0, 1'b0,
                                      known_result(FUNC_UPDATE, 1, 0, 1)));
    directed_rows.push_back(known_row(FUNC_UPDATE, 63, 1200, 1'b0,
                                      known_result(FUNC_UPDATE, 0, 0, 1)));
    directed_rows.push_back(known_row(FUNC_UPDATE, 63, 1199, 1'b0,
                                      known_result(FUNC_UPDATE, 1, 0, 0)));
    directed_rows.push_back(known_row(FUNC_LOAD, 63, 0, 1'b1,
                                      known_result(FUNC_LOAD, 0, 0, 1)));
    directed_rows.push_back(known_row(FUNC_LOAD, 10, 0, 1'b0,
                                      known_result(FUNC_LOAD, 0, 0, 0)));
    directed_rows.push_back(known_row(FUNC_RSVD, 63, 65535, 1'b1,
                                      known_result(FUNC_RSVD, 0, 1, 0)));
    directed_rows.push_back(plain_row(FUNC_MEASURE, 0, 0, 1'b0));
    directed_rows.push_back(reg_row(ADDR_RING_LENGTH, 8));
    directed_rows.push_back(known_row(FUNC_UPDATE, 8, 0, 1'b0,
                                      known_result(FUNC_UPDATE, 0, 1, 0)));
    directed_rows.push_back(known_row(FUNC_LOAD, 63, 0, 1'b1,
                                      known_result(FUNC_LOAD, 0, 1, 0)));
    directed_rows.push_back(known_row(FUNC_LOAD, 7, 0, 1'b0,
                                      known_result(FUNC_LOAD, 0, 0, 0)));
    directed_rows.push_back(plain_row(FUNC_UPDATE, 0, 65535, 1'b0));
    directed_rows.push_back(plain_row(FUNC_MEASURE, 5, 0, 1'b0));
    directed_rows.push_back(reg_row(ADDR_ACCEPT_THR, 0));
    directed_rows.push_back(known_row(FUNC_UPDATE, 2, 0, 1'b0,
                                      known_result(FUNC_UPDATE, 0, 0, 1)));
    directed_rows.push_back(reg_row(ADDR_ACCEPT_THR, 65535));
    directed_rows.push_back(known_row(FUNC_UPDATE, 2, 65535, 1'b0,
                                      known_result(FUNC_UPDATE, 0, 0, 1)));
    directed_rows.push_back(known_row(FUNC_UPDATE, 2, 65534, 1'b0,
                                      known_result(FUNC_UPDATE, 1, 0, 0)));
    directed_rows.push_back(reg_row(ADDR_RING_LENGTH, 1));
    directed_rows.push_back(plain_row(FUNC_MEASURE, 0, 0, 1'b0));
    directed_rows.push_back(known_row(FUNC_UPDATE, 2, 0, 1'b0,
                                      known_result(FUNC_UPDATE, 0, 1, 0)));
    directed_rows.push_back(plain_row(FUNC_UPDATE, 1, 65535, 1'b0));
    directed_rows.push_back(reg_row(ADDR_RING_LENGTH, 127));
    directed_rows.push_back(plain_row(FUNC_MEASURE, 63, 0, 1'b0));
    directed_rows.push_back(known_row(FUNC_LOAD, 63, 0, 1'b0,
                                      known_result(FUNC_LOAD, 0, 0, 0)));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_REG_WRITE) begin
        settle();
        write_reg(directed_rows[i].addr, directed_rows[i].data);
      end else begin
        send_request(directed_rows[i].req, directed_rows[i].known, directed_rows[i].want);
      end
    end

    // random phases, each under a fresh register setting
    for (int p = 0; p < PHASE_COUNT; p++) begin
      settle();
      calm_tail = (p == PHASE_COUNT - 1);
      thr = (PHASE_THR[p] < 0) ? int'($urandom_range(65535)) : PHASE_THR[p];
      write_reg(ADDR_RING_LENGTH, PHASE_LEN[p]);
      write_reg(ADDR_ACCEPT_THR, thr);
      for (int n = 0; n < PHASE_REQ[p]; n++) begin
        // mid-phase, let the pipeline drain completely
        if (n == PHASE_REQ[p] / 2) settle();
        if (!calm_tail && $urandom_range(5) == 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(16, 1)) @(posedge clk_i);
        end
        send_request(random_request(), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (ring_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_ising_ring_metropolis_update: PASS");
    end else begin
      $display("tb_ising_ring_metropolis_update: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/irm_pkg.sv
sv/irm_cell.sv
sv/irm_tree.sv
sv/ising_ring_metropolis_update.sv
dv/tb_ising_ring_metropolis_update.sv
